// File: hw/rtl/gab_pkg.sv
// gab_pkg: shared types and constants for the gf2 affine basis engine
// no dependencies, used by gab_cell and gf2_affine_basis_engine
package gab_pkg;

  // default vector width
  localparam int unsigned VectorBitsDef = 32;

  // control that travels with the residue down the cell chain
  typedef struct packed {
    logic valid;   // a token sits in this stage
    logic insert;  // insert beat, else query
    logic found;   // a free pivot was hit higher up, reduction is over
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

endpackage

// File: hw/rtl/gab_cell.sv
// gab_cell: one pivot of the basis, reduces the passing residue by one bit
// depends on gab_pkg
module gab_cell #(
  parameter int unsigned VECTOR_BITS = gab_pkg::VectorBitsDef,
  parameter int unsigned PIVOT       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  gab_pkg::cell_ctl_t     ctl_i,
  input  logic [VECTOR_BITS-1:0] res_i,
  output gab_pkg::cell_ctl_t     ctl_o,
  output logic [VECTOR_BITS-1:0] res_o
);

  gab_pkg::cell_ctl_t     ctl_d, ctl_q;
  logic [VECTOR_BITS-1:0] res_d, res_q;
  logic [VECTOR_BITS-1:0] word_q;
  logic                   occ_q;
  logic                   store;

  always_comb begin
    ctl_d = ctl_i;
    res_d = res_i;
    store = 1'b0;
    if (ctl_i.valid && !ctl_i.found && res_i[PIVOT]) begin
      if (occ_q) begin
        res_d = res_i ^ word_q;
      end else begin
        // free pivot: the residue stops here, an insert claims it
        ctl_d.found = 1'b1;
        store       = ctl_i.insert;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      occ_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (clear_i) begin
        occ_q <= 1'b0;
      end else if (store) begin
        occ_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (store) begin
      word_q <= res_i;
    end
  end

  assign ctl_o = ctl_q;
  assign res_o = res_q;

endmodule

// File: hw/rtl/gf2_affine_basis_engine.sv
// gf2_affine_basis_engine: top level, entry stage, cell chain and result register
// depends on gab_pkg and gab_cell
//
// The block keeps an xor basis of VECTOR_BITS-bit words, one pivot per cell,
// cells ordered from the top bit down. An insert beat (func 0) offsets its
// vector by the held origin in affine mode, then walks the chain one cell per
// cycle; the first cell whose pivot bit is set and free stores the residue.
// The first insert in affine mode with no origin held becomes the origin instead.
// A query beat (func 1) walks the same chain and stores nothing. start_req
// clears the basis, origin, rank and count before its own beat. One beat is
// in flight at a time: the entry register loads at the accepting edge, then
// one register per cell and the result register; in_ready returns in the
// same cycle that result valid rises. The output register holds one finished
// result, all fields frozen, while the next beat runs; the cfg port is always
// ready and takes the affine_mode bit (reset 1), which the user must write only
// while the block is idle; the block itself does not enforce this.
module gf2_affine_basis_engine #(
  parameter int unsigned VECTOR_BITS = gab_pkg::VectorBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_affine_mode_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic        start_req_i,
  input  logic [31:0] vector_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        in_span_o,
  output logic        added_o,
  output logic [5:0]  rank_o,
  output logic [31:0] origin_o,
  output logic [31:0] point_count_o
);

  localparam int unsigned RankW = $clog2(VECTOR_BITS + 1);

  // configuration register
  logic affine_q;

  // engine state
  logic [VECTOR_BITS-1:0] origin_q;
  logic                   origin_vld_q;
  logic [RankW-1:0]       rank_q;
  logic [31:0]            points_q;

  // chain stages, stage 0 is the entry register
  gab_pkg::cell_ctl_t     ctl_s [VECTOR_BITS+1];
  logic [VECTOR_BITS-1:0] res_s [VECTOR_BITS+1];

  gab_pkg::cell_ctl_t     ent_ctl_d, ent_ctl_q;
  logic [VECTOR_BITS-1:0] ent_res_q;
  logic                   hit_q;     // beat became the origin

  // finished token parked while the output register is full
  gab_pkg::cell_ctl_t     fin_ctl_q;

  // output register
  logic                   out_valid_q;
  logic                   in_span_q;
  logic                   added_q;
  logic [RankW-1:0]       rank_out_q;
  logic [VECTOR_BITS-1:0] origin_out_q;
  logic [31:0]            count_out_q;

  gab_pkg::state_e state_q, state_d;

  logic                   in_acc;
  logic                   clear;
  logic                   slot_free;
  logic                   fin_take;
  logic                   fin_park;
  gab_pkg::cell_ctl_t     fin_ctl;
  logic                   fin_add;
  logic [RankW-1:0]       rank_nx;
  logic [VECTOR_BITS-1:0] vec_m;
  logic [VECTOR_BITS+31:0] vec_ext;
  logic                   ov_eff;
  logic [31:0]            pts_base;
  logic                   take_origin;

  assign cfg_ready_o = 1'b1;

  // vector masked or zero-extended to VECTOR_BITS
  assign vec_ext = {{VECTOR_BITS{1'b0}}, vector_i};
  assign vec_m   = vec_ext[VECTOR_BITS-1:0];

  assign in_acc    = in_valid_i && in_ready_o;
  assign clear     = in_acc && start_req_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // state as seen by this beat, after an optional start
  assign ov_eff      = origin_vld_q && !start_req_i;
  assign pts_base    = start_req_i ? 32'd0 : points_q;
  assign take_origin = !func_i && affine_q && !ov_eff;

  // finished insert that claimed a pivot
  assign fin_add = fin_ctl.insert && fin_ctl.found && !hit_q;
  assign rank_nx = rank_q + RankW'(fin_add);

  // entry token, lives for one cycle
  always_comb begin
    ent_ctl_d = '0;
    if (in_acc) begin
      ent_ctl_d.valid  = 1'b1;
      ent_ctl_d.insert = !func_i;
      // origin beat skips all cells
      ent_ctl_d.found  = take_origin;
    end
  end

  // next state and handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    fin_take   = 1'b0;
    fin_park   = 1'b0;
    fin_ctl    = ctl_s[VECTOR_BITS];
    case (state_q)
      gab_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = gab_pkg::ST_RUN;
        end
      end
      gab_pkg::ST_RUN: begin
        if (ctl_s[VECTOR_BITS].valid) begin
          if (slot_free) begin
            fin_take = 1'b1;
            state_d  = gab_pkg::ST_IDLE;
          end else begin
            fin_park = 1'b1;
            state_d  = gab_pkg::ST_HOLD;
          end
        end
      end
      gab_pkg::ST_HOLD: begin
        fin_ctl = fin_ctl_q;
        if (slot_free) begin
          fin_take = 1'b1;
          state_d  = gab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gab_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gab_pkg::ST_IDLE;
      affine_q     <= 1'b1;
      origin_q     <= '0;
      origin_vld_q <= 1'b0;
      rank_q       <= '0;
      points_q     <= '0;
      ent_ctl_q    <= '0;
      fin_ctl_q    <= '0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      ent_ctl_q <= ent_ctl_d;
      if (cfg_valid_i) begin
        affine_q <= cfg_affine_mode_i;
      end

      if (in_acc) begin
        hit_q <= take_origin;
        if (take_origin) begin
          origin_q     <= vec_m;
          origin_vld_q <= 1'b1;
        end else if (start_req_i) begin
          origin_q     <= '0;
          origin_vld_q <= 1'b0;
        end
        if (start_req_i) begin
          rank_q <= '0;
        end
        if (!func_i) begin
          points_q <= (pts_base == 32'hFFFF_FFFF) ? pts_base : pts_base + 32'd1;
        end else if (start_req_i) begin
          points_q <= '0;
        end
      end

      if (fin_park) begin
        fin_ctl_q <= ctl_s[VECTOR_BITS];
      end

      // result register
      if (fin_take) begin
        out_valid_q <= 1'b1;
        rank_q      <= rank_nx;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!func_i && affine_q && ov_eff) begin
        ent_res_q <= vec_m ^ origin_q;
      end else begin
        ent_res_q <= vec_m;
      end
    end
    // snapshot of the state after this beat, held while the result waits
    if (fin_take) begin
      in_span_q    <= hit_q || !fin_ctl.found;
      added_q      <= fin_add;
      rank_out_q   <= rank_nx;
      origin_out_q <= origin_q;
      count_out_q  <= points_q;
    end
  end

  assign ctl_s[0] = ent_ctl_q;
  assign res_s[0] = ent_res_q;

  // cell chain, top pivot first
  for (genvar i = 0; i < VECTOR_BITS; i++) begin : g_cell
    gab_cell #(
      .VECTOR_BITS(VECTOR_BITS),
      .PIVOT      (VECTOR_BITS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clear_i(clear),
      .ctl_i  (ctl_s[i]),
      .res_i  (res_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .res_o  (res_s[i+1])
    );
  end

  // outputs, rank and origin fitted to the port widths
  logic [RankW+5:0]        rank_ext;
  logic [VECTOR_BITS+31:0] origin_ext;

  assign rank_ext   = {6'b0, rank_out_q};
  assign origin_ext = {32'b0, origin_out_q};

  assign out_valid_o   = out_valid_q;
  assign in_span_o     = in_span_q;
  assign added_o       = added_q;
  assign rank_o        = rank_ext[5:0];
  assign origin_o      = origin_ext[31:0];
  assign point_count_o = count_out_q;

endmodule

// File: tb/gab_basis_checker.sv
// gab_basis_checker: watches the cfg, input and result channels of the basis engine,
// predicts every result from its own copy of the basis and compares field by field
// depends on gab_pkg for the vector width
module gab_basis_checker #(
  parameter logic FuncInsert = 1'b0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_affine_mode_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic        start_req_i,
  input  logic [31:0] vector_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        in_span_i,
  input  logic        added_i,
  input  logic [5:0]  rank_i,
  input  logic [31:0] origin_i,
  input  logic [31:0] point_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VecBits     = gab_pkg::VectorBitsDef;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic        in_span;
    logic        added;
    logic [5:0]  rank;
    logic [31:0] origin;
    logic [31:0] point_count;
  } span_result_t;

  logic [31:0]  pivot_word [VecBits];
  logic [31:0]  origin_q;
  logic         origin_set;
  logic [5:0]   rank_q;
  logic [31:0]  count_q;
  logic         affine_q;
  span_result_t span_results_q [$];

  function automatic void clear_basis();
    for (int i = 0; i < VecBits; i++) pivot_word[i] = '0;
    origin_q   = '0;
    origin_set = 1'b0;
    rank_q     = '0;
    count_q    = '0;
  endfunction

  // walk from the top bit down, returns the free pivot hit or -1 when the residue dies
  function automatic int find_pivot(inout logic [31:0] resid);
    int piv;
    piv = -1;
    for (int b = VecBits - 1; b >= 0; b--) begin
      if (piv < 0 && resid[b]) begin
        if (pivot_word[b] == '0) piv = b;
        else resid ^= pivot_word[b];
      end
    end
    return piv;
  endfunction

  function automatic span_result_t predict_beat(logic f, logic s, logic [31:0] v);
    span_result_t res;
    logic [31:0]  resid;
    int           piv;
    res = '0;
    if (s) clear_basis();
    if (f == FuncInsert) begin
      if (count_q != '1) count_q++;
      if (affine_q && !origin_set) begin
        // first point becomes the origin and offsets to zero
        origin_q    = v;
        origin_set  = 1'b1;
        res.in_span = 1'b1;
      end else begin
        resid = (affine_q && origin_set) ? (v ^ origin_q) : v;
        piv   = find_pivot(resid);
        if (piv < 0) begin
          res.in_span = 1'b1;
        end else begin
          pivot_word[piv] = resid;
          rank_q++;
          res.added = 1'b1;
        end
      end
    end else begin
      // query: no origin offset, no state change
      resid       = v;
      res.in_span = (find_pivot(resid) < 0);
    end
    res.rank        = rank_q;
    res.origin      = origin_q;
    res.point_count = count_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    span_result_t got;
    span_result_t want;
    logic         bad;
    if (!rst_ni) begin
      clear_basis();
      affine_q = 1'b1;
      span_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare before pushing so a result never meets its own beat's prediction early
      if (out_valid_i && out_ready_i) begin
        got = {in_span_i, added_i, rank_i, origin_i, point_count_i};
        if (span_results_q.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t: unexpected result beat: span=%0d added=%0d rank=%0d %s",
                     $time, got.in_span, got.added, got.rank,
                     $sformatf("origin=%h count=%h", got.origin, got.point_count));
          fail_count_o++;
        end else begin
          want = span_results_q.pop_front();
          bad  = (got.in_span !== want.in_span) || (got.added !== want.added) ||
                 (got.rank !== want.rank) || (got.origin !== want.origin) ||
                 (got.point_count !== want.point_count);
          if (bad) begin
            if (fail_count_o < ReportLimit) begin
              $display("%0t: mismatch exp span=%0d added=%0d rank=%0d origin=%h count=%h",
                       $time, want.in_span, want.added, want.rank, want.origin,
                       want.point_count);
              $display("%0t:          got span=%0d added=%0d rank=%0d origin=%h count=%h",
                       $time, got.in_span, got.added, got.rank, got.origin,
                       got.point_count);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) affine_q = cfg_affine_mode_i;
      if (in_valid_i && in_ready_i)
        span_results_q.push_back(predict_beat(func_i, start_req_i, vector_i));
      pending_o = span_results_q.size();
    end
  end

endmodule

// File: tb/tb_gf2_affine_basis_engine.sv
// tb_gf2_affine_basis_engine: stimulus and verdict for the gf2 affine basis engine
// depends on gab_pkg, gf2_affine_basis_engine and gab_basis_checker
module tb_gf2_affine_basis_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // func codes and affine_mode settings
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_AFFINE = 1'b1;

  localparam int unsigned PHASES       = 4;
  localparam int unsigned PHASE_BEATS  = 200;
  // long receiver hold-off, starts once this many results have been taken
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  // one beat walks entry stage, one stage per bit and the result register
  localparam int unsigned TAIL_CYCLES  = gab_pkg::VectorBitsDef + 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_affine_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_INSERT;
  logic        start_req = 1'b0;
  logic [31:0] vector = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        in_span;
  logic        added;
  logic [5:0]  rank;
  logic [31:0] origin;
  logic [31:0] point_count;

  int unsigned fail_count;
  int unsigned pending;

  // idle percentages of the current phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned rx_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always #4 clk = ~clk;

  gf2_affine_basis_engine u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_affine_mode_i(cfg_affine_mode),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .start_req_i      (start_req),
    .vector_i         (vector),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .in_span_o        (in_span),
    .added_o          (added),
    .rank_o           (rank),
    .origin_o         (origin),
    .point_count_o    (point_count)
  );

  gab_basis_checker #(
    .FuncInsert(FUNC_INSERT)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_affine_mode_i(cfg_affine_mode),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func),
    .start_req_i      (start_req),
    .vector_i         (vector),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .in_span_i        (in_span),
    .added_i          (added),
    .rank_i           (rank),
    .origin_i         (origin),
    .point_count_i    (point_count),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // count result beats, sampled at the rising edge
  always @(posedge clk) begin
    if (out_valid && out_ready) rx_count <= rx_count + 1;
  end

  // result side: random stalls per phase, plus one long hold-off so the
  // output register and the chain fill up and in_ready drops
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && rx_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a falling edge; leaves valid high on return so back-to-back
  // beats never drop and raise it in the same step
  task automatic send_beat(input logic f, input logic s, input logic [31:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    start_req <= s;
    vector    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mode writes only happen with the block drained
  task automatic write_mode(input logic m);
    cfg_valid       <= 1'b1;
    cfg_affine_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hard stop in case a handshake never completes
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic        phase_mode [PHASES];
    int unsigned phase_idle [PHASES];
    int unsigned phase_stall [PHASES];
    logic [31:0] point_hist [$];
    logic [31:0] v;
    logic        f;
    logic        s;
    int unsigned seq_left;
    int unsigned kind;

    phase_mode  = '{MODE_AFFINE, MODE_LINEAR, MODE_AFFINE, MODE_LINEAR};
    phase_idle  = '{0, 80, 0, 31};
    phase_stall = '{0, 0, 80, 31};
    seq_left    = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, affine mode ----
    write_mode(MODE_AFFINE);
    // origin insert: all ones becomes the origin, offsets to zero
    send_beat(FUNC_INSERT, 1'b1, 32'hFFFF_FFFF);
    // repeat of the origin lies in the span, only counts
    send_beat(FUNC_INSERT, 1'b0, 32'hFFFF_FFFF);
    // zero offsets to all ones, first pivot at the top bit
    send_beat(FUNC_INSERT, 1'b0, 32'h0000_0000);
    send_beat(FUNC_INSERT, 1'b0, 32'h7FFF_FFFF);
    send_beat(FUNC_QUERY,  1'b0, 32'h8000_0000);
    send_beat(FUNC_QUERY,  1'b0, 32'h0000_0001);
    send_beat(FUNC_QUERY,  1'b0, 32'h0000_0000);
    send_beat(FUNC_INSERT, 1'b0, 32'hFFFF_FFFE);
    // query with start clears everything first
    send_beat(FUNC_QUERY,  1'b1, 32'h0000_0000);
    send_beat(FUNC_QUERY,  1'b0, 32'hDEAD_BEEF);

    // ---- linear mode: no origin, no offset ----
    wait_drained();
    write_mode(MODE_LINEAR);
    send_beat(FUNC_INSERT, 1'b1, 32'h0000_0000);
    send_beat(FUNC_INSERT, 1'b0, 32'h8000_0001);
    send_beat(FUNC_INSERT, 1'b0, 32'h0000_0001);
    send_beat(FUNC_INSERT, 1'b0, 32'h8000_0000);
    send_beat(FUNC_QUERY,  1'b0, 32'hFFFF_FFFF);
    send_beat(FUNC_INSERT, 1'b0, 32'hAAAA_AAAA);
    send_beat(FUNC_INSERT, 1'b0, 32'h5555_5555);
    send_beat(FUNC_QUERY,  1'b0, 32'hFFFF_FFFF);

    // ---- mode change mid-run: next insert takes the origin without a start ----
    wait_drained();
    write_mode(MODE_AFFINE);
    send_beat(FUNC_INSERT, 1'b0, 32'h1234_5678);
    send_beat(FUNC_INSERT, 1'b0, 32'h1234_5679);

    // back to linear with an origin held: origin stays, offset stops
    wait_drained();
    write_mode(MODE_LINEAR);
    send_beat(FUNC_INSERT, 1'b0, 32'h1234_5678);
    send_beat(FUNC_QUERY,  1'b0, 32'h1234_5678);

    // ---- random phases ----
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_mode(phase_mode[ph]);
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // mostly well-formed runs opened by a start, some long enough to reach
        // full rank; a few runs continue without a start, a few starts land mid-run
        if (seq_left == 0) begin
          seq_left = ($urandom_range(3) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 1);
          s = ($urandom_range(9) != 0);
        end else begin
          s = ($urandom_range(49) == 0);
        end
        seq_left--;
        if (s) point_hist.delete();
        f    = ($urandom_range(3) == 0) ? FUNC_QUERY : FUNC_INSERT;
        kind = $urandom_range(99);
        if (kind < 35) begin
          v = $urandom;
        end else if (kind < 55) begin
          // sparse words, one to three bits set, hit pivots directly
          v = '0;
          repeat ($urandom_range(3, 1)) v[$urandom_range(31)] = 1'b1;
        end else if (kind < 70 && point_hist.size() != 0) begin
          // repeated point, in the span when reinserted with the same offset
          v = point_hist[$urandom_range(point_hist.size() - 1)];
        end else if (kind < 85 && point_hist.size() != 0) begin
          // sum of two points cancels the origin, a query of it lies in the span
          v = point_hist[$urandom_range(point_hist.size() - 1)] ^
              point_hist[$urandom_range(point_hist.size() - 1)];
        end else if (kind < 92) begin
          case ($urandom_range(2))
            0:       v = '0;
            1:       v = '1;
            default: v = 32'h8000_0000;
          endcase
        end else begin
          // narrow words exercise the low pivots
          v = $urandom & ((32'h1 << $urandom_range(31, 1)) - 1);
        end
        if (f == FUNC_INSERT) point_hist.push_back(v);
        send_beat(f, s, v);
      end
    end

    // drain, then give the chain a full walk to expose any stray result beat
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
